// File: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int DATA_W = 32;
	localparam int DIV_N = DATA_W + FRAC_BITS;
	localparam int CELLS = DIV_N;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_CMP = 4'd4,
		CMD_MIN = 4'd5,
		CMD_MAX = 4'd6,
		CMD_INC = 4'd7,
		CMD_DEC = 4'd8,
		CMD_FROM_INT = 4'd9,
		CMD_TO_INT = 4'd10
	} cmd_t;

	typedef struct packed {
		logic [DIV_N-1:0] num;
		logic [DIV_N-1:0] rem;
		logic [DATA_W-1:0] den;
		logic [DATA_W-1:0] res;
		logic neg;
		logic is_div;
		logic lt;
		logic gt;
		logic eq;
		logic dz;
	} cell_t;
endpackage

// File: rtl/fpa_stream_if.sv
`timescale 1ns / 1ps
interface fpa_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fpa_front.sv
`timescale 1ns / 1ps
module fpa_front (
	input logic [3:0] cmd,
	input logic [31:0] a,
	input logic [31:0] b,
	input logic [63:0] prod,
	output fpa_pkg::cell_t head
);
	logic signed [31:0] sa, sb;
	logic [63:0] mag;
	logic [63:0] pq;
	logic [31:0] ma, mb, tq;
	always_comb begin
		sa = a;
		sb = b;
		ma = sa[31] ? 32'(-sa) : a;
		mb = sb[31] ? 32'(-sb) : b;
		mag = prod[63] ? 64'(-prod) : prod;
		pq = prod[63] ? 64'(-(mag >> fpa_pkg::FRAC_BITS)) : (mag >> fpa_pkg::FRAC_BITS);
		tq = sa[31] ? 32'(-(ma >> fpa_pkg::FRAC_BITS)) : (ma >> fpa_pkg::FRAC_BITS);
		head = '0;
		head.lt = sa < sb;
		head.gt = sa > sb;
		head.eq = a == b;
		head.den = mb;
		head.neg = sa[31] ^ sb[31];
		head.num = {ma, {fpa_pkg::FRAC_BITS{1'b0}}};
		case (cmd)
			fpa_pkg::CMD_ADD: head.res = a + b;
			fpa_pkg::CMD_SUB: head.res = a - b;
			fpa_pkg::CMD_MUL: head.res = pq[31:0];
			fpa_pkg::CMD_DIV: begin
				head.dz = b == '0;
				head.is_div = b != '0;
			end
			fpa_pkg::CMD_MIN: head.res = (sa < sb) ? a : b;
			fpa_pkg::CMD_MAX: head.res = (sa > sb) ? a : b;
			fpa_pkg::CMD_INC: head.res = a + 32'd1;
			fpa_pkg::CMD_DEC: head.res = a - 32'd1;
			fpa_pkg::CMD_FROM_INT: head.res = a << fpa_pkg::FRAC_BITS;
			fpa_pkg::CMD_TO_INT: head.res = tq;
			default: head.res = '0;
		endcase
	end
endmodule

// File: rtl/fpa_div_cell.sv
`timescale 1ns / 1ps
module fpa_div_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input fpa_pkg::cell_t din,
	output logic vout,
	output fpa_pkg::cell_t dout
);
	logic [fpa_pkg::DIV_N:0] trial;
	logic [fpa_pkg::DIV_N-1:0] shifted;
	fpa_pkg::cell_t nxt;
	always_comb begin
		nxt = din;
		shifted = {din.rem[fpa_pkg::DIV_N-2:0], din.num[fpa_pkg::DIV_N-1]};
		trial = {1'b0, shifted} - {{(fpa_pkg::DIV_N-fpa_pkg::DATA_W+1){1'b0}}, din.den};
		nxt.num = {din.num[fpa_pkg::DIV_N-2:0], ~trial[fpa_pkg::DIV_N]};
		nxt.rem = trial[fpa_pkg::DIV_N] ? shifted : trial[fpa_pkg::DIV_N-1:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

// File: rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Signed Q24.8 ALU, one word in and one result out per cycle while the output
// is not stalled. Multiply is registered once in the input stage, then every
// word walks a chain of 40 restoring-division cells (one quotient bit per
// cell), so the results of all commands leave through the last cell, and a
// stall at the output freezes the whole chain.
module fixed_point_alu (
	input logic clk,
	input logic arst_n,
	fpa_stream_if.sink in_if,
	fpa_stream_if.source out_if
);
	localparam int N = fpa_pkg::CELLS;
	logic en;
	logic [3:0] cmd_s1;
	logic [31:0] a_s1, b_s1;
	logic [63:0] prod_s1;
	logic v_s1;
	fpa_pkg::cell_t front;
	logic v [N+1];
	fpa_pkg::cell_t c [N+1];
	logic [31:0] q;

	assign en = !out_if.valid || out_if.ready;
	assign in_if.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_if.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_if.data[67:64];
			a_s1 <= in_if.data[63:32];
			b_s1 <= in_if.data[31:0];
			prod_s1 <= 64'($signed(in_if.data[63:32]) * $signed(in_if.data[31:0]));
		end
	end

	fpa_front u_front (.cmd(cmd_s1), .a(a_s1), .b(b_s1), .prod(prod_s1), .head(front));
	assign c[0] = front;
	assign v[0] = v_s1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		fpa_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en), .vin(v[i]), .din(c[i]),
			.vout(v[i+1]), .dout(c[i+1]));
	end

	always_comb begin
		q = c[N].neg ? 32'(-c[N].num) : c[N].num[31:0];
		out_if.valid = v[N];
		out_if.data = {c[N].is_div ? q : c[N].res, c[N].lt, c[N].gt, c[N].eq, c[N].dz};
	end
endmodule
